// ===== rtl/lsu_pkg.sv =====
// Shared types and constants for the literal string unescaper.
`default_nettype none
package lsu_pkg;

    localparam int MAX_DEPTH_DEF = 255;
    localparam int Q_DEPTH       = 4;
    localparam int Q_IDX_W       = $clog2(Q_DEPTH);
    localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0c;

    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_BODY = 3'd1;
    localparam logic [2:0] MODE_ESC  = 3'd2;
    localparam logic [2:0] MODE_OCT1 = 3'd3;
    localparam logic [2:0] MODE_OCT2 = 3'd4;

    // one result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       last;
        logic       error;
    } res_t;

endpackage
`default_nettype wire

// ===== rtl/lsu_in_if.sv =====
// Input byte channel.
`default_nettype none
interface lsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/lsu_out_if.sv =====
// Decoded result channel.
`default_nettype none
interface lsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       last;
    logic       error;

    modport source (output valid, output out_byte, output out_valid, output last,
                    output error, input ready);
    modport sink   (input valid, input out_byte, input out_valid, input last,
                    input error, output ready);
endinterface
`default_nettype wire

// ===== rtl/lsu_decode.sv =====
// Parser state registers and per-byte decode logic.
`default_nettype none
module lsu_decode #(
    parameter int MAX_DEPTH = 255
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        take,
    input  wire logic [7:0]  in_byte,
    output lsu_pkg::res_t    res0,
    output lsu_pkg::res_t    res1,
    output logic [1:0]       res_cnt
);
    import lsu_pkg::*;

    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);

    typedef struct packed {
        logic [2:0]         mode;
        logic [DEPTH_W-1:0] depth;
        logic               skip;
        logic               emit;
        res_t               res;
    } body_t;

    logic [2:0]         mode_reg, mode_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [7:0]         acc_reg, acc_next;
    logic               skip_reg, skip_next;

    function automatic res_t mk(input logic [7:0] b, input logic v,
                                input logic l, input logic e);
        res_t r;
        r.out_byte  = b;
        r.out_valid = v;
        r.last      = l;
        r.error     = e;
        return r;
    endfunction

    // ordinary string body byte
    function automatic body_t body_step(input logic [7:0] b, input logic skip,
                                        input logic [DEPTH_W-1:0] depth);
        body_t o;
        o.mode  = MODE_BODY;
        o.depth = depth;
        o.skip  = (b == CH_CR);
        o.emit  = 1'b1;
        o.res   = mk(b, 1'b1, 1'b0, 1'b0);
        if (skip && b == CH_LF) begin
            o.emit = 1'b0;
        end else if (b == CH_LPAREN) begin
            if (depth >= DEPTH_MAX) begin
                o.mode  = MODE_IDLE;
                o.depth = '0;
                o.res   = mk(8'h00, 1'b0, 1'b0, 1'b1);
            end else begin
                o.depth = depth + 1'b1;
            end
        end else if (b == CH_RPAREN) begin
            if (depth == '0) begin
                o.mode = MODE_IDLE;
                o.res  = mk(8'h00, 1'b0, 1'b1, 1'b0);
            end else begin
                o.depth = depth - 1'b1;
            end
        end else if (b == CH_BSLASH) begin
            o.mode = MODE_ESC;
            o.emit = 1'b0;
        end else if (b == CH_CR) begin
            o.res = mk(CH_LF, 1'b1, 1'b0, 1'b0);
        end
        return o;
    endfunction

    logic       is_oct;
    logic [2:0] digit;
    logic [7:0] acc_shift;
    body_t      bo_cur;
    body_t      bo_flush;

    assign is_oct    = (in_byte >= CH_ZERO) && (in_byte <= CH_SEVEN);
    assign digit     = in_byte[2:0];
    assign acc_shift = {acc_reg[4:0], digit};
    assign bo_cur    = body_step(in_byte, skip_reg, depth_reg);
    assign bo_flush  = body_step(in_byte, 1'b0, depth_reg);

    always_comb
    begin
        mode_next  = mode_reg;
        depth_next = depth_reg;
        acc_next   = acc_reg;
        skip_next  = skip_reg;
        res0       = mk(8'h00, 1'b0, 1'b0, 1'b0);
        res1       = mk(8'h00, 1'b0, 1'b0, 1'b0);
        res_cnt    = 2'd0;
        case (mode_reg)
            MODE_BODY:
            begin
                mode_next  = bo_cur.mode;
                depth_next = bo_cur.depth;
                skip_next  = bo_cur.skip;
                res0       = bo_cur.res;
                res_cnt    = {1'b0, bo_cur.emit};
            end
            MODE_ESC:
            begin
                mode_next = MODE_BODY;
                skip_next = 1'b0;
                res_cnt   = 2'd1;
                if (in_byte == CH_CR) begin
                    skip_next = 1'b1;
                    res_cnt   = 2'd0;
                end else if (in_byte == CH_LF) begin
                    res_cnt = 2'd0;
                end else if (is_oct) begin
                    acc_next  = {5'd0, digit};
                    mode_next = MODE_OCT1;
                    res_cnt   = 2'd0;
                end else begin
                    case (in_byte)
                        CH_N:    res0 = mk(CH_LF, 1'b1, 1'b0, 1'b0);
                        CH_R:    res0 = mk(CH_CR, 1'b1, 1'b0, 1'b0);
                        CH_T:    res0 = mk(CH_TAB, 1'b1, 1'b0, 1'b0);
                        CH_B:    res0 = mk(CH_BS, 1'b1, 1'b0, 1'b0);
                        CH_F:    res0 = mk(CH_FF, 1'b1, 1'b0, 1'b0);
                        default: res0 = mk(in_byte, 1'b1, 1'b0, 1'b0);
                    endcase
                end
            end
            MODE_OCT1, MODE_OCT2:
            begin
                if (is_oct) begin
                    acc_next = acc_shift;
                    if (mode_reg == MODE_OCT1) begin
                        mode_next = MODE_OCT2;
                    end else begin
                        mode_next = MODE_BODY;
                        res0      = mk(acc_shift, 1'b1, 1'b0, 1'b0);
                        res_cnt   = 2'd1;
                    end
                end else begin
                    // flush the octal value, then treat the byte as body text
                    res0       = mk(acc_reg, 1'b1, 1'b0, 1'b0);
                    res1       = bo_flush.res;
                    res_cnt    = bo_flush.emit ? 2'd2 : 2'd1;
                    mode_next  = bo_flush.mode;
                    depth_next = bo_flush.depth;
                    skip_next  = bo_flush.skip;
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
                if (in_byte == CH_LPAREN) begin
                    mode_next  = MODE_BODY;
                    depth_next = '0;
                    acc_next   = 8'h00;
                    skip_next  = 1'b0;
                end else begin
                    res0    = mk(8'h00, 1'b0, 1'b0, 1'b1);
                    res_cnt = 2'd1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_IDLE;
            depth_reg <= '0;
            acc_reg   <= 8'h00;
            skip_reg  <= 1'b0;
        end else if (take) begin
            mode_reg  <= mode_next;
            depth_reg <= depth_next;
            acc_reg   <= acc_next;
            skip_reg  <= skip_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/lsu_outq.sv =====
// Small result queue that takes up to two results per cycle and gives one.
`default_nettype none
module lsu_outq (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [1:0]                push_cnt,
    input  wire lsu_pkg::res_t             push0,
    input  wire lsu_pkg::res_t             push1,
    input  wire logic                      pop,
    output lsu_pkg::res_t                  head,
    output logic [lsu_pkg::Q_CNT_W-1:0]    count
);
    import lsu_pkg::*;

    res_t               q_reg [Q_DEPTH];
    logic [Q_IDX_W-1:0] wr_reg, wr_next;
    logic [Q_IDX_W-1:0] rd_reg, rd_next;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic [Q_IDX_W-1:0] wr_idx1;

    assign wr_idx1 = wr_reg + 1'b1;
    assign head    = q_reg[rd_reg];
    assign count   = cnt_reg;

    always_comb
    begin
        wr_next  = wr_reg + Q_IDX_W'(push_cnt);
        rd_next  = rd_reg + Q_IDX_W'(pop);
        cnt_next = cnt_reg + Q_CNT_W'(push_cnt) - Q_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0) begin
            q_reg[wr_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            q_reg[wr_idx1] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/literal_string_unescaper_unit.sv =====
// Top level of the PDF literal string unescaper.
//
// din carries raw stream bytes, starting at the opening parenthesis; dout
// carries decoded results: out_byte/out_valid for string bytes, last on the
// closing parenthesis, error for a stray byte while idle or nesting overflow.
// Each byte updates the parser state in the cycle of its transfer; its results
// are written into a four-entry result queue and appear on dout from there.
// Throughput: one byte per cycle while din.ready is high. A byte that ends an
// octal escape can yield two results, which the queue drains one per cycle
// while dout.ready is high.
// din.ready is high while at least two queue entries are free (registered
// count, no path from dout.ready to din.ready); a stalled receiver fills the
// queue and then holds off input, results stay in order and are never lost.
// Reset clears the parser to idle (awaiting an opening parenthesis) and
// empties the queue. Bytes that produce no result (escape leaders, the first
// two octal digits, an opening parenthesis while idle) pass with no output.
`default_nettype none
module literal_string_unescaper_unit #(
    parameter int MAX_DEPTH = lsu_pkg::MAX_DEPTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lsu_in_if.sink     din,
    lsu_out_if.source  dout
);
    import lsu_pkg::*;

    logic               take;
    logic               pop;
    res_t               res0;
    res_t               res1;
    logic [1:0]         res_cnt;
    logic [1:0]         push_cnt;
    res_t               head;
    logic [Q_CNT_W-1:0] q_count;

    assign din.ready = (q_count <= Q_CNT_W'(Q_DEPTH - 2));
    assign take      = din.valid && din.ready;
    assign push_cnt  = take ? res_cnt : 2'd0;
    assign pop       = dout.valid && dout.ready;

    lsu_decode #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .in_byte (din.in_byte),
        .res0    (res0),
        .res1    (res1),
        .res_cnt (res_cnt)
    );

    lsu_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (push_cnt),
        .push0    (res0),
        .push1    (res1),
        .pop      (pop),
        .head     (head),
        .count    (q_count)
    );

    assign dout.valid     = (q_count != '0);
    assign dout.out_byte  = head.out_byte;
    assign dout.out_valid = head.out_valid;
    assign dout.last      = head.last;
    assign dout.error     = head.error;

    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue over capacity");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_count != '0)
        else $error("result transfer from empty queue");

    a_pair_after_octal: assert property (@(posedge clk) disable iff (!rst_n)
        (take && res_cnt == 2'd2) |-> res0.out_valid && !res0.last && !res0.error)
        else $error("two results without a pending octal value");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (!take && !pop) |=> $stable(q_count))
        else $error("queue count moved without a transfer");

endmodule
`default_nettype wire

// ===== sim/lsu_unescape_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the literal string unescaper: predicts decoded results and compares them.
module lsu_unescape_checker #(
    parameter int MAX_DEPTH = lsu_pkg::MAX_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    lsu_in_if           din,
    lsu_out_if          dout,
    output int unsigned mismatches,
    output int unsigned pending
);
    import lsu_pkg::*;

    logic [2:0]  p_mode;
    int unsigned p_depth;
    logic [7:0]  p_octal;
    logic        p_skip_lf;
    res_t        decoded_q [$];

    function automatic bit is_octal_digit(input logic [7:0] b);
        return b >= CH_ZERO && b <= CH_SEVEN;
    endfunction

    task automatic push_decoded(input logic [7:0] b, input logic v, input logic l,
                                input logic e);
        res_t r;
        r.out_byte  = b;
        r.out_valid = v;
        r.last      = l;
        r.error     = e;
        decoded_q.push_back(r);
    endtask

    task automatic take_body_byte(input logic [7:0] b);
        logic drop;
        // LF right after a CR belongs to the same line end
        drop      = p_skip_lf && b == CH_LF;
        p_skip_lf = 1'b0;
        if (!drop)
        begin
            if (b == CH_LPAREN)
            begin
                if (p_depth >= MAX_DEPTH)
                begin
                    p_mode  = MODE_IDLE;
                    p_depth = 0;
                    push_decoded(8'h00, 1'b0, 1'b0, 1'b1);
                end
                else
                begin
                    p_depth++;
                    push_decoded(b, 1'b1, 1'b0, 1'b0);
                end
            end
            else if (b == CH_RPAREN)
            begin
                if (p_depth == 0)
                begin
                    p_mode = MODE_IDLE;
                    push_decoded(8'h00, 1'b0, 1'b1, 1'b0);
                end
                else
                begin
                    p_depth--;
                    push_decoded(b, 1'b1, 1'b0, 1'b0);
                end
            end
            else if (b == CH_BSLASH)
                p_mode = MODE_ESC;
            else if (b == CH_CR)
            begin
                p_skip_lf = 1'b1;
                push_decoded(CH_LF, 1'b1, 1'b0, 1'b0);
            end
            else
                push_decoded(b, 1'b1, 1'b0, 1'b0);
        end
    endtask

    task automatic unescape_byte(input logic [7:0] b);
        case (p_mode)
            MODE_BODY: take_body_byte(b);
            MODE_ESC:
            begin
                p_mode    = MODE_BODY;
                p_skip_lf = 1'b0;
                if (b == CH_CR)
                    p_skip_lf = 1'b1;
                else if (is_octal_digit(b))
                begin
                    p_octal = b - CH_ZERO;
                    p_mode  = MODE_OCT1;
                end
                else if (b != CH_LF)
                begin
                    case (b)
                        CH_N:    push_decoded(CH_LF, 1'b1, 1'b0, 1'b0);
                        CH_R:    push_decoded(CH_CR, 1'b1, 1'b0, 1'b0);
                        CH_T:    push_decoded(CH_TAB, 1'b1, 1'b0, 1'b0);
                        CH_B:    push_decoded(CH_BS, 1'b1, 1'b0, 1'b0);
                        CH_F:    push_decoded(CH_FF, 1'b1, 1'b0, 1'b0);
                        default: push_decoded(b, 1'b1, 1'b0, 1'b0);
                    endcase
                end
            end
            MODE_OCT1, MODE_OCT2:
            begin
                if (is_octal_digit(b))
                begin
                    p_octal = (p_octal << 3) + (b - CH_ZERO);
                    if (p_mode == MODE_OCT1)
                        p_mode = MODE_OCT2;
                    else
                    begin
                        p_mode = MODE_BODY;
                        push_decoded(p_octal, 1'b1, 1'b0, 1'b0);
                    end
                end
                else
                begin
                    // flush the short octal run, then treat b as a body byte
                    p_mode    = MODE_BODY;
                    p_skip_lf = 1'b0;
                    push_decoded(p_octal, 1'b1, 1'b0, 1'b0);
                    take_body_byte(b);
                end
            end
            default:
            begin
                p_mode = MODE_IDLE;
                if (b == CH_LPAREN)
                begin
                    p_mode    = MODE_BODY;
                    p_depth   = 0;
                    p_octal   = 8'h00;
                    p_skip_lf = 1'b0;
                end
                else
                    push_decoded(8'h00, 1'b0, 1'b0, 1'b1);
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            p_mode    = MODE_IDLE;
            p_depth   = 0;
            p_octal   = 8'h00;
            p_skip_lf = 1'b0;
            decoded_q.delete();
            mismatches = 0;
            pending   <= 0;
        end
        else
        begin
            if (din.valid && din.ready)
                unescape_byte(din.in_byte);
            if (dout.valid && dout.ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    $error("unexpected result transfer: out_byte %0h out_valid %0b last %0b error %0b",
                           dout.out_byte, dout.out_valid, dout.last, dout.error);
                    mismatches++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    check_field("out_byte", want.out_byte, dout.out_byte);
                    check_field("out_valid", want.out_valid, dout.out_valid);
                    check_field("last", want.last, dout.last);
                    check_field("error", want.error, dout.error);
                end
            end
            pending <= decoded_q.size();
        end
    end

endmodule

// ===== sim/tb_literal_string_unescaper_unit.sv =====
`timescale 1ns / 100ps
// Testbench top for the literal string unescaper: byte stimulus, flow control and verdict.
module tb_literal_string_unescaper_unit;
    import lsu_pkg::*;

    localparam int ITEM_TARGET = 650;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 60;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        calm = 1'b0;
    int unsigned hold_stamp = 0;
    int unsigned hold_seen = 0;
    int unsigned n_sent = 0;
    int unsigned cycle_cnt = 0;
    int unsigned mismatches;
    int unsigned pending;

    lsu_in_if  din_if ();
    lsu_out_if dout_if ();

    literal_string_unescaper_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (din_if),
        .dout  (dout_if)
    );

    lsu_unescape_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .din        (din_if),
        .dout       (dout_if),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin : rx_side
        int k;
        dout_if.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_stamp)
            begin
                hold_seen = hold_stamp;
                dout_if.ready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++)
                    @(posedge clk);
            end
            dout_if.ready <= calm || $urandom_range(0, 99) >= 11;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (!calm && $urandom_range(0, 99) < 11)
        begin
            din_if.valid <= 1'b0;
            @(posedge clk);
        end
        din_if.valid   <= 1'b1;
        din_if.in_byte <= b;
        @(posedge clk);
        while (!din_if.ready)
            @(posedge clk);
        n_sent++;
    endtask

    function automatic logic [7:0] rand_plain();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_LPAREN || b == CH_RPAREN || b == CH_BSLASH);
        return b;
    endfunction

    // balanced string with random escapes, octal runs, line ends and nesting
    task automatic send_string(input int unsigned n_tok);
        int unsigned depth;
        int unsigned k;
        int unsigned j;
        int unsigned r;
        depth = 0;
        send_byte(CH_LPAREN);
        for (k = 0; k < n_tok; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                send_byte(rand_plain());
            else if (r < 55)
            begin
                send_byte(CH_BSLASH);
                case ($urandom_range(0, 8))
                    0: send_byte(CH_N);
                    1: send_byte(CH_R);
                    2: send_byte(CH_T);
                    3: send_byte(CH_B);
                    4: send_byte(CH_F);
                    5: send_byte(CH_LPAREN);
                    6: send_byte(CH_RPAREN);
                    7: send_byte(CH_BSLASH);
                    default: send_byte(8'($urandom_range(0, 255)));
                endcase
            end
            else if (r < 70)
            begin
                send_byte(CH_BSLASH);
                for (j = $urandom_range(1, 3); j > 0; j--)
                    send_byte(CH_ZERO + 8'($urandom_range(0, 7)));
                if ($urandom_range(0, 1))
                    send_byte(rand_plain());
            end
            else if (r < 80)
            begin
                if ($urandom_range(0, 1))
                    send_byte(CH_BSLASH);
                case ($urandom_range(0, 2))
                    0: send_byte(CH_CR);
                    1: send_byte(CH_LF);
                    default:
                    begin
                        send_byte(CH_CR);
                        send_byte(CH_LF);
                    end
                endcase
            end
            else if (r < 90 && depth < 16)
            begin
                send_byte(CH_LPAREN);
                depth++;
            end
            else if (depth > 0)
            begin
                send_byte(CH_RPAREN);
                depth--;
            end
            else
                send_byte(rand_plain());
        end
        repeat (depth + 1)
            send_byte(CH_RPAREN);
    endtask

    // opening byte, raw noise, then a few closers that may land while idle
    task automatic send_broken();
        send_byte(CH_LPAREN);
        repeat ($urandom_range(1, 10))
            send_byte(8'($urandom_range(0, 255)));
        repeat (3)
            send_byte(CH_RPAREN);
    endtask

    initial
    begin
        logic [7:0] warmup [$];
        int unsigned r;
        bit held;
        bit drained;
        bit deep_done;
        held      = 1'b0;
        drained   = 1'b0;
        deep_done = 1'b0;
        // stray bytes, body extremes, named and unknown escapes, octal truncation, short octal
        // run closed by the end parenthesis, line ends, line continuation, nesting
        warmup = '{8'hFF, 8'h00, CH_LPAREN, 8'hFF, 8'h00,
                   CH_BSLASH, CH_N, CH_BSLASH, CH_R, CH_BSLASH, CH_T,
                   CH_BSLASH, CH_B, CH_BSLASH, CH_F, CH_BSLASH, CH_LPAREN,
                   CH_BSLASH, 8'h78, CH_BSLASH, CH_SEVEN, CH_SEVEN, CH_SEVEN,
                   CH_CR, CH_LF, CH_BSLASH, CH_CR, CH_LF, CH_LPAREN, CH_RPAREN,
                   CH_BSLASH, CH_ZERO + 8'd1, CH_ZERO + 8'd2, CH_RPAREN};
        din_if.valid   <= 1'b0;
        din_if.in_byte <= 8'h00;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (warmup[i])
            send_byte(warmup[i]);

        while (n_sent < ITEM_TARGET)
        begin
            calm <= n_sent >= 260 && n_sent < 360;
            if (!held && n_sent >= 120)
            begin
                held = 1'b1;
                hold_stamp <= hold_stamp + 1;
            end
            if (!drained && n_sent >= 420)
            begin
                drained = 1'b1;
                din_if.valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            if (!deep_done && n_sent >= 500)
            begin
                // enough opening bytes to overflow the nesting depth from any state
                deep_done = 1'b1;
                repeat (MAX_DEPTH_DEF + 2)
                    send_byte(CH_LPAREN);
            end
            r = $urandom_range(0, 99);
            if (r < 75)
                send_string($urandom_range(0, 12));
            else if (r < 88)
                send_broken();
            else
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom_range(0, 255)));
        end

        din_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lsu_pkg.sv
rtl/lsu_in_if.sv
rtl/lsu_out_if.sv
rtl/lsu_decode.sv
rtl/lsu_outq.sv
rtl/literal_string_unescaper_unit.sv
sim/lsu_unescape_checker.sv
sim/tb_literal_string_unescaper_unit.sv
